// File: rtl/core/stbk_pkg.sv
`default_nettype none

package stbk_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ReqW = 2;
  localparam int IdW = 8;
  localparam int DurW = 32;
  localparam int StatusW = 3;

  localparam logic [ReqW-1:0] REQ_START_ONCE     = 2'd0;
  localparam logic [ReqW-1:0] REQ_START_PERIODIC = 2'd1;
  localparam logic [ReqW-1:0] REQ_TICK           = 2'd2;
  localparam logic [ReqW-1:0] REQ_CHECK          = 2'd3;

  localparam logic [StatusW-1:0] ST_OK          = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_ID      = 3'd1;
  localparam logic [StatusW-1:0] ST_IN_USE      = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_IN_USE  = 3'd3;
  localparam logic [StatusW-1:0] ST_EXPIRED     = 3'd4;
  localparam logic [StatusW-1:0] ST_NOT_EXPIRED = 3'd5;

  typedef enum logic {
    StIdle,
    StRun
  } stbk_state_e;

  typedef struct packed {
    logic [DurW-1:0] count;
    logic [DurW-1:0] reload;
    logic            in_use;
    logic            expired;
    logic            periodic;
  } timer_rec_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            hit;
    logic [DurW-1:0] dur;
  } upd_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/multi_channel_soft_timer_bank.sv
// Bank of countdown timers, one-shot or periodic, driven by a request channel.
// Input channel (in_valid_i/in_ready_o): one transaction is a request made of
// req_type_i (start one-shot, start periodic, tick, check), timer_id_i and
// duration_i. Output channel (out_valid_o/out_ready_i): one status per request.
// The timers sit in a ring of cells that rotates by one place per cycle while
// a request is served (unless stopped as below); a single update unit at the
// head of the ring serves the timer passing it, so a request takes one full turn.
// The next request is taken in the last cycle of the current turn.
// Reset clears every timer (not in use, not expired, one-shot, counts zero)
// and drops any pending status.
// When the receiver stalls, the status is held in the output register; the
// ring stops just before its last step until that register is free, so no
// further request is taken meanwhile.
`default_nettype none

module multi_channel_soft_timer_bank
  import stbk_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [ReqW-1:0]     req_type_i,
  input  wire  [IdW-1:0]      timer_id_i,
  input  wire  [DurW-1:0]     duration_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [StatusW-1:0]  status_o
);

  stbk_state_e state_q, state_d;
  logic [IdxW-1:0] step_q, step_d;
  logic [ReqW-1:0] req_q, req_d;
  logic [IdW-1:0] id_q, id_d;
  logic [DurW-1:0] dur_q, dur_d;
  logic [StatusW-1:0] st_q, st_d;
  logic out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;

  logic last;
  logic can_finish;
  logic advance;
  logic accept;

  timer_rec_t ring [NUM_TIMERS];
  timer_rec_t head_upd;
  upd_ctrl_t ctrl;
  logic [StatusW-1:0] hit_status;

  assign ctrl.req = req_q;
  assign ctrl.hit = (req_q != REQ_TICK) && (id_q == IdW'(step_q));
  assign ctrl.dur = dur_q;

  stbk_update u_update (
    .ctrl_i   (ctrl),
    .rec_i    (ring[0]),
    .rec_o    (head_upd),
    .status_o (hit_status)
  );

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    if (k == NUM_TIMERS - 1) begin : g_tail
      stbk_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (advance),
        .rec_i   (head_upd),
        .rec_o   (ring[k])
      );
    end else begin : g_body
      stbk_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (advance),
        .rec_i   (ring[k+1]),
        .rec_o   (ring[k])
      );
    end
  end

  assign last       = (step_q == IdxW'(NUM_TIMERS - 1));
  assign can_finish = !out_valid_q || out_ready_i;
  assign advance    = (state_q == StRun) && (!last || can_finish);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    req_d       = req_q;
    id_d        = id_q;
    dur_d       = dur_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StRun: begin
        in_ready_o = last && can_finish;
        if (advance) begin
          if (ctrl.hit) begin
            st_d = hit_status;
          end
          step_d = step_q + IdxW'(1);
          if (last) begin
            out_valid_d = 1'b1;
            status_d    = ctrl.hit ? hit_status : st_q;
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (accept) begin
      state_d = StRun;
      step_d  = '0;
      req_d   = req_type_i;
      id_d    = timer_id_i;
      dur_d   = duration_i;
      if ((req_type_i != REQ_TICK) && (timer_id_i >= IdW'(NUM_TIMERS))) begin
        st_d = ST_BAD_ID;
      end else begin
        st_d = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    dur_q    <= dur_d;
    st_q     <= st_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// File: rtl/core/stbk_cell.sv
`default_nettype none

module stbk_cell
  import stbk_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        shift_i,
  input  timer_rec_t rec_i,
  output timer_rec_t rec_o
);

  timer_rec_t rec_q;
  timer_rec_t rec_d;

  always_comb begin
    rec_d = rec_q;
    if (shift_i) begin
      rec_d = rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

// File: rtl/core/stbk_update.sv
`default_nettype none

module stbk_update
  import stbk_pkg::*;
(
  input  upd_ctrl_t             ctrl_i,
  input  timer_rec_t            rec_i,
  output timer_rec_t            rec_o,
  output logic [StatusW-1:0]    status_o
);

  logic [DurW-1:0] dec;

  assign dec = rec_i.count - DurW'(1);

  always_comb begin
    rec_o    = rec_i;
    status_o = ST_OK;
    case (ctrl_i.req)
      REQ_TICK: begin
        if (rec_i.in_use && (rec_i.count != '0)) begin
          rec_o.count = dec;
          if (dec == '0) begin
            rec_o.expired = 1'b1;
            if (rec_i.periodic) begin
              rec_o.count = rec_i.reload;
            end
          end
        end
      end
      REQ_START_ONCE, REQ_START_PERIODIC: begin
        if (ctrl_i.hit) begin
          if (rec_i.in_use) begin
            status_o = ST_IN_USE;
          end else begin
            rec_o.count    = ctrl_i.dur;
            rec_o.reload   = ctrl_i.dur;
            rec_o.in_use   = 1'b1;
            rec_o.periodic = (ctrl_i.req == REQ_START_PERIODIC);
            status_o       = ST_OK;
          end
        end
      end
      REQ_CHECK: begin
        if (ctrl_i.hit) begin
          if (!rec_i.in_use) begin
            status_o = ST_NOT_IN_USE;
          end else if (!rec_i.expired) begin
            status_o = ST_NOT_EXPIRED;
          end else begin
            rec_o.expired = 1'b0;
            if (!rec_i.periodic) begin
              rec_o.in_use = 1'b0;
            end
            status_o = ST_EXPIRED;
          end
        end
      end
      default: begin
        rec_o    = rec_i;
        status_o = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/stbk_checker.sv
`default_nettype none

module stbk_checker
  import stbk_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input wire [StatusW-1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("status dropped or changed while stalled");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= ST_NOT_EXPIRED))
    else $error("status code out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (NUM_TIMERS > 1) |=> !in_ready_o)
    else $error("request taken while the ring is still turning");

  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("status valid during reset");

endmodule

bind multi_channel_soft_timer_bank stbk_checker u_stbk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o)
);

`default_nettype wire
